// ===== design/manchester_frame_encoder_macros.svh =====
// assertion macros for the manchester frame encoder
`ifndef MANCHESTER_FRAME_ENCODER_MACROS_SVH
`define MANCHESTER_FRAME_ENCODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define MFE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define MFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/mfe_pkg.sv =====
// package with frame constants and the nibble encoder for the manchester frame encoder
package mfe_pkg;

   localparam int PREAMBLE_COUNT_DEFAULT = 8;

   localparam logic [7:0] PREAMBLE_BYTE = 8'h55;
   localparam logic [7:0] START_BYTE    = 8'hA4;
   localparam logic [7:0] END_BYTE      = 8'hA0;
   localparam logic [1:0] CODE_ONE      = 2'b01;
   localparam logic [1:0] CODE_ZERO     = 2'b10;

   // each bit becomes a pair, bit 0 in the lowest pair
   function automatic logic [7:0] encode_nibble(input logic [3:0] nib);
      logic [7:0] code;
      code = 8'h00;
      for (int j = 0; j < 4; j++) begin
         code[2*j +: 2] = nib[j] ? CODE_ONE : CODE_ZERO;
      end
      return code;
   endfunction

endpackage

// ===== design/manchester_frame_encoder.sv =====
// top level of the manchester frame encoder: item register, byte sequencer, result register
//
//   channel | direction | ports
//   --------+-----------+------------------------------------------------------
//   req     | in        | req_valid, req_ready, req_data_byte, req_byte_present,
//           |           | req_end_of_frame
//   rsp     | out       | rsp_valid, rsp_ready, rsp_out_byte, rsp_last_of_run
//
// one result byte leaves per cycle while rsp_ready is not stalled; an item gives
// 2 result bytes for a data byte inside a frame, plus PREAMBLE_COUNT + 1 when it
// opens a frame, plus 2 when it closes one. idle items are taken and give nothing.
// the next item is taken in the cycle the last byte of the current one moves
// into the result register. reset is synchronous and clears the frame state;
// a stalled rsp_ready holds the result and the sequencer.
`include "manchester_frame_encoder_macros.svh"

module manchester_frame_encoder
   import mfe_pkg::*;
#(
   parameter int PREAMBLE_COUNT = PREAMBLE_COUNT_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_byte_present,
   input  logic       req_end_of_frame,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_of_run
);

   localparam int CNT_W = (PREAMBLE_COUNT > 1) ? $clog2(PREAMBLE_COUNT) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PREAMBLE_COUNT - 1);

   typedef enum logic [2:0] {
      PH_PRE,
      PH_START,
      PH_HI,
      PH_LO,
      PH_SUM,
      PH_END
   } phase_type;

   // frame state
   logic       in_frame_ff;
   logic [7:0] running_sum_ff;

   // item register
   logic             hold_valid_ff;
   phase_type        phase_ff;
   logic [CNT_W-1:0] count_ff;
   logic [7:0]       hi_ff;
   logic [7:0]       lo_ff;
   logic [7:0]       chk_ff;
   logic             has_data_ff;
   logic             has_eof_ff;

   // result register
   logic       rsp_valid_ff;
   logic [7:0] rsp_out_byte_ff;
   logic       rsp_last_ff;

   logic       accept;
   logic       take;
   logic       load;
   logic       is_last;
   logic [7:0] hi_in;
   logic [7:0] lo_in;
   logic [7:0] sum_in;
   logic [7:0] chk_in;
   phase_type  start_phase;
   phase_type  phase_in;
   logic [CNT_W-1:0] count_in;
   logic [7:0] byte_in;

   // encode the incoming byte and work out the checksum it leaves
   always_comb begin
      hi_in  = encode_nibble(req_data_byte[7:4]);
      lo_in  = encode_nibble(req_data_byte[3:0]);
      sum_in = req_byte_present ? 8'(running_sum_ff + hi_in + lo_in) : running_sum_ff;
      chk_in = sum_in;
      if (!in_frame_ff) begin
         start_phase = PH_PRE;
      end else if (req_byte_present) begin
         start_phase = PH_HI;
      end else begin
         start_phase = PH_SUM;
      end
   end

   // handshake between the item register and the result register
   assign load    = hold_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign is_last = (phase_ff == PH_END) || ((phase_ff == PH_LO) && !has_eof_ff);
   assign req_ready = !hold_valid_ff || (load && is_last);
   assign accept  = req_valid && req_ready;
   assign take    = accept && (req_byte_present || req_end_of_frame);

   // sequencer step and the byte for the current phase
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      byte_in  = PREAMBLE_BYTE;
      case (phase_ff)
         PH_PRE: begin
            byte_in = PREAMBLE_BYTE;
            if (count_ff == CNT_LAST) begin
               phase_in = PH_START;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         PH_START: begin
            byte_in  = START_BYTE;
            phase_in = has_data_ff ? PH_HI : PH_SUM;
         end
         PH_HI: begin
            byte_in  = hi_ff;
            phase_in = PH_LO;
         end
         PH_LO: begin
            byte_in  = lo_ff;
            phase_in = PH_SUM;
         end
         PH_SUM: begin
            byte_in  = chk_ff;
            phase_in = PH_END;
         end
         PH_END: begin
            byte_in  = END_BYTE;
            phase_in = PH_END;
         end
         default: begin
            byte_in  = END_BYTE;
            phase_in = PH_END;
         end
      endcase
   end

   // control state, frame state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff    <= 1'b0;
         running_sum_ff <= 8'h00;
         hold_valid_ff  <= 1'b0;
         phase_ff       <= PH_PRE;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (take) begin
            hold_valid_ff  <= 1'b1;
            phase_ff       <= start_phase;
            count_ff       <= '0;
            in_frame_ff    <= !req_end_of_frame;
            running_sum_ff <= req_end_of_frame ? 8'h00 : sum_in;
         end else if (load && is_last) begin
            hold_valid_ff <= 1'b0;
         end else if (load) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload of the item register and the result register
   always_ff @(posedge clock) begin
      if (take) begin
         hi_ff       <= hi_in;
         lo_ff       <= lo_in;
         chk_ff      <= chk_in;
         has_data_ff <= req_byte_present;
         has_eof_ff  <= req_end_of_frame;
      end
      if (load) begin
         rsp_out_byte_ff <= byte_in;
         rsp_last_ff     <= is_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_out_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // checks on the sequencer
   `MFE_ASSERT_SAME(a_done_shows_last, clock, reset, rsp_valid_ff && !hold_valid_ff, rsp_last_ff, "result pending with no item but not marked last")
   `MFE_ASSERT_SAME(a_pre_count_range, clock, reset, hold_valid_ff && (phase_ff == PH_PRE), count_ff <= CNT_LAST, "preamble count out of range")
   `MFE_ASSERT_SAME(a_sum_needs_eof, clock, reset, hold_valid_ff && ((phase_ff == PH_SUM) || (phase_ff == PH_END)), has_eof_ff, "checksum phase on an item that does not close the frame")
   `MFE_ASSERT_NEXT(a_end_byte_out, clock, reset, load && (phase_ff == PH_END), rsp_valid_ff && rsp_last_ff && (rsp_out_byte_ff == END_BYTE), "end byte not presented as last result")

endmodule

// ===== tb/manchester_frame_encoder_test.sv =====
// self-checking testbench for the manchester frame encoder: directed table, then random frames
module manchester_frame_encoder_test
   import mfe_pkg::*;
();

   localparam int NUM_PREAMBLE = PREAMBLE_COUNT_DEFAULT;
   localparam int RANDOM_ITEMS = 432;
   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 800000;
   localparam int NUM_ROWS     = 18;

   // one input item, with optional hand-typed encoded bytes and checksum
   typedef struct packed {
      logic [7:0] data;
      logic       present;
      logic       eof;
      logic       typed;
      logic [7:0] hi;
      logic [7:0] lo;
      logic [7:0] sum;
   } stim_row_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } frame_byte_type;

   // directed items: idle, empty frames, extremes, close with and without data
   localparam stim_row_type DIRECTED [NUM_ROWS] = '{
      '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
      '{8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00},
      '{8'h00, 1'b1, 1'b0, 1'b1, 8'hAA, 8'hAA, 8'h00},
      '{8'hFF, 1'b1, 1'b0, 1'b1, 8'h55, 8'h55, 8'h00},
      '{8'h5A, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
      '{8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 8'h00, 8'hFE},
      '{8'hA5, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
      '{8'h01, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
      '{8'h80, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
      '{8'h0F, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
      '{8'hF0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
      '{8'h3C, 1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00},
      '{8'hFF, 1'b1, 1'b1, 1'b1, 8'h55, 8'h55, 8'hAA},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
      '{8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 8'h00, 8'h00},
      '{8'h12, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
      '{8'h34, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00},
      '{8'h56, 1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00}
   };

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_data_byte;
   logic       req_byte_present;
   logic       req_end_of_frame;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic       rsp_last_of_run;

   frame_byte_type expected_bytes [$];
   logic           frame_open;
   logic [7:0]     byte_sum;
   int             mismatch_count;
   bit             burst_mode;
   bit             hold_request;
   bit             hold_active;

   manchester_frame_encoder #(
      .PREAMBLE_COUNT(NUM_PREAMBLE)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_byte_present (req_byte_present),
      .req_end_of_frame (req_end_of_frame),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // one bit per pair, bit 3 in the top pair
   function automatic logic [7:0] manchester_nibble(input logic [3:0] nib);
      return {nib[3] ? CODE_ONE : CODE_ZERO, nib[2] ? CODE_ONE : CODE_ZERO,
              nib[1] ? CODE_ONE : CODE_ZERO, nib[0] ? CODE_ONE : CODE_ZERO};
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 8);
      return $urandom_range(16, 32);
   endfunction

   // extremes often, otherwise any byte
   function automatic logic [7:0] pick_data();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 8'h00;
      if (r < 20) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // frame bytes caused by one accepted item
   task automatic predict_item(input stim_row_type row);
      logic [7:0]     hi;
      logic [7:0]     lo;
      frame_byte_type tail;
      if (!row.present && !row.eof) return;
      if (!frame_open) begin
         repeat (NUM_PREAMBLE) expected_bytes.push_back('{PREAMBLE_BYTE, 1'b0});
         expected_bytes.push_back('{START_BYTE, 1'b0});
         frame_open = 1'b1;
      end
      if (row.present) begin
         hi = manchester_nibble(row.data[7:4]);
         lo = manchester_nibble(row.data[3:0]);
         byte_sum = byte_sum + hi + lo;
         expected_bytes.push_back('{row.typed ? row.hi : hi, 1'b0});
         expected_bytes.push_back('{row.typed ? row.lo : lo, 1'b0});
      end
      if (row.eof) begin
         expected_bytes.push_back('{row.typed ? row.sum : byte_sum, 1'b0});
         expected_bytes.push_back('{END_BYTE, 1'b0});
         byte_sum = 8'h00;
         frame_open = 1'b0;
      end
      // mark the final byte of this item
      tail = expected_bytes.pop_back();
      tail.last = 1'b1;
      expected_bytes.push_back(tail);
   endtask

   // offer one item after a random gap (none in burst mode or during a hold) and wait for its acceptance
   task automatic offer_item(input stim_row_type row);
      int gap;
      gap = (burst_mode || hold_active) ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_data_byte    <= row.data;
      req_byte_present <= row.present;
      req_end_of_frame <= row.eof;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(row);
   endtask

   // lower valid and wait until every expected byte has arrived
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   // receiver: random stalls, one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left == 0 && hold_request) begin
            hold_request = 1'b0;
            hold_active  = 1'b1;
            stall_left   = HOLD_CYCLES;
         end else if (stall_left == 0) begin
            hold_active = 1'b0;
            if (!burst_mode && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare each accepted result with the oldest expected byte
   always @(posedge clock) begin : result_check
      frame_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected item out_byte=%h last_of_run=%b",
                     $time, rsp_out_byte, rsp_last_of_run);
            mismatch_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.out_byte) begin
               $display("%0t: out_byte expected %h actual %h",
                        $time, want.out_byte, rsp_out_byte);
               mismatch_count++;
            end
            if (rsp_last_of_run !== want.last) begin
               $display("%0t: last_of_run expected %b actual %b",
                        $time, want.last, rsp_last_of_run);
               mismatch_count++;
            end
         end
      end
   end

   // run limit
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("manchester_frame_encoder_test failed");
      $finish;
   end

   // stimulus and final verdict
   initial begin
      stim_row_type row;
      int           count;
      int           r;
      bit           hold_done;
      bit           pause_done;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data_byte    = 8'h00;
      req_byte_present = 1'b0;
      req_end_of_frame = 1'b0;
      frame_open       = 1'b0;
      byte_sum         = 8'h00;
      mismatch_count   = 0;
      burst_mode       = 1'b0;
      hold_request     = 1'b0;
      hold_active      = 1'b0;
      hold_done        = 1'b0;
      pause_done       = 1'b0;
      count            = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < NUM_ROWS; i++) offer_item(DIRECTED[i]);

      // random frames: mostly data, some closes, a little idle noise
      while (count < RANDOM_ITEMS) begin
         if (count == 120 && !hold_done) begin
            hold_done    = 1'b1;
            hold_request = 1'b1;
         end
         if (count == 250 && !pause_done) begin
            pause_done = 1'b1;
            drain_results();
         end
         burst_mode = (count >= 300 && count < 340);
         r = $urandom_range(0, 99);
         row.data    = pick_data();
         row.typed   = 1'b0;
         row.hi      = 8'h00;
         row.lo      = 8'h00;
         row.sum     = 8'h00;
         row.present = (r >= 8 && r < 88);
         row.eof     = (r >= 70);
         offer_item(row);
         count++;
      end
      burst_mode = 1'b0;
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("manchester_frame_encoder_test passed");
      end else begin
         $display("manchester_frame_encoder_test failed");
      end
      $finish;
   end

endmodule
